[hw/rtl/lms_pkg.sv]
// Package for the terminal mux line scanner.
// Holds command codes, control and status bit positions, and the request and
// result structs shared by the engine and the top level.
`default_nettype none

package lms_pkg;

  localparam int POS_W      = 5;   // scanner position / line number width
  localparam int LINE_CNT_W = 6;   // line_count register width
  localparam int PTR_W      = 6;   // send pointer width
  localparam int WORD_W     = 12;
  localparam int CHAR_W     = 8;
  localparam int CHAN_W     = 3;
  localparam int CMD_W      = 4;
  localparam int MASK_W     = 32;

  localparam logic [LINE_CNT_W-1:0] LINE_CNT_RESET = 6'd16;
  localparam logic [PTR_W-1:0]      PTR_OFFSET     = 6'd2;

  // control write bits
  localparam int CTL_RX_CH_LSB  = 0;
  localparam int CTL_RX_RELEASE = 3;
  localparam int CTL_RX_RESET   = 4;
  localparam int CTL_TX_CH_LSB  = 6;
  localparam int CTL_TX_RELEASE = 11;

  // status word bits
  localparam int STAT_RX_CH_LSB = 0;
  localparam int STAT_RX_IDLE   = 3;
  localparam int STAT_TX_CH_LSB = 6;
  localparam int STAT_TX_IDLE   = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_STATUS_RD  = 4'd0,
    CMD_CTRL_WR    = 4'd1,
    CMD_DOUT_SCAN  = 4'd2,
    CMD_DOUT_PTR   = 4'd3,
    CMD_DIN        = 4'd4,
    CMD_DIN_REARM  = 4'd5,
    CMD_SCAN_RD    = 4'd6,
    CMD_SET_PTR    = 4'd7,
    CMD_POLL       = 4'd8
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [WORD_W-1:0] data_word;
    logic              connect_valid;
    logic [POS_W-1:0]  connect_line;
    logic [MASK_W-1:0] pending_mask;
    logic              line_connected;
    logic              rx_has_data;
    logic [CHAR_W-1:0] rx_char;
    logic              rx_break;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              tx_valid;
    logic [POS_W-1:0]  tx_line;
    logic [CHAR_W-1:0] tx_char;
    logic              rx_take;
    logic              irq_active;
    logic [CHAN_W-1:0] irq_channel;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/lms_find.sv]
// Wrap-around next-set-bit search: rotated priority encoder over the bitmap.
// Uses lms_pkg for the position width.
`default_nettype none

module lms_find #(
  parameter int SCAN_WIDTH = 32
) (
  input  wire logic [SCAN_WIDTH-1:0]    bits,
  input  wire logic [lms_pkg::POS_W-1:0] pos,
  output logic                          hit,
  output logic [lms_pkg::POS_W-1:0]     found
);
  import lms_pkg::*;

  logic [POS_W-1:0]      start;
  logic [SCAN_WIDTH-1:0] upper;
  logic [POS_W-1:0]      upper_idx;
  logic [POS_W-1:0]      any_idx;

  // out-of-range start wraps to line 0
  assign start = ({1'b0, pos} >= (POS_W+1)'(SCAN_WIDTH)) ? '0 : pos;

  always_comb begin
    for (int i = 0; i < SCAN_WIDTH; i++) begin
      upper[i] = bits[i] && (POS_W'(i) >= start);
    end
  end

  always_comb begin
    upper_idx = '0;
    any_idx   = '0;
    for (int i = SCAN_WIDTH-1; i >= 0; i--) begin
      if (upper[i]) upper_idx = POS_W'(i);
      if (bits[i])  any_idx   = POS_W'(i);
    end
  end

  assign hit   = |bits;
  assign found = (|upper) ? upper_idx : any_idx;

endmodule

`default_nettype wire

[hw/rtl/lms_engine.sv]
// Scanner state and per-request update: bitmaps, scanners, pointer, interrupt.
// Depends on lms_pkg and two lms_find instances.
`default_nettype none

module lms_engine #(
  parameter int SCAN_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire lms_pkg::item_t                item,
  input  wire logic [lms_pkg::LINE_CNT_W-1:0] line_count,
  output lms_pkg::result_t                   result
);
  import lms_pkg::*;

  logic [CHAN_W-1:0]     rx_channel, tx_channel;
  logic                  rx_scan_armed, tx_scan_armed;
  logic [POS_W-1:0]      rx_position, tx_position;
  logic [PTR_W-1:0]      send_pointer_line;
  logic [SCAN_WIDTH-1:0] ready_bits, enable_bits;
  logic                  irq_state;
  logic [CHAN_W-1:0]     irq_level;

  // state after the command's own changes, before the scan
  logic [CHAN_W-1:0]     pre_rx_ch, pre_tx_ch;
  logic                  pre_rx_armed, pre_tx_armed;
  logic [POS_W-1:0]      pre_rx_pos;
  logic [PTR_W-1:0]      pre_ptr;
  logic [SCAN_WIDTH-1:0] pre_ready, pre_enable;
  logic                  do_scan;
  logic [WORD_W-1:0]     pre_rd;
  logic                  txv, take;
  logic [POS_W-1:0]      txl;
  logic [CHAR_W-1:0]     txc;

  logic                  rx_armed_next, tx_armed_next;
  logic [POS_W-1:0]      rx_position_next, tx_position_next;
  logic                  irq_state_next;
  logic [CHAN_W-1:0]     irq_level_next;
  logic [WORD_W-1:0]     rd;

  logic                  rx_hit, tx_hit;
  logic [POS_W-1:0]      rx_found, tx_found;

  logic [LINE_CNT_W-1:0] limit;
  logic [SCAN_WIDTH-1:0] limit_mask;
  logic [LINE_CNT_W-1:0] ln;
  logic                  ln_ok;
  logic [SCAN_WIDTH-1:0] ln_mask;
  logic [SCAN_WIDTH-1:0] conn_mask;

  assign limit = (line_count > LINE_CNT_W'(SCAN_WIDTH)) ? LINE_CNT_W'(SCAN_WIDTH) : line_count;

  always_comb begin
    for (int i = 0; i < SCAN_WIDTH; i++) begin
      limit_mask[i] = (LINE_CNT_W'(i) < limit);
    end
  end

  // target line of the data-out and data-in requests
  always_comb begin
    ln    = {1'b0, rx_position};
    ln_ok = 1'b1;
    case (cmd_t'(item.command))
      CMD_DOUT_SCAN: ln = {1'b0, tx_position};
      CMD_DOUT_PTR: begin
        ln    = send_pointer_line - PTR_OFFSET;
        ln_ok = (send_pointer_line >= PTR_OFFSET);
      end
      default: ln = {1'b0, rx_position};
    endcase
  end

  assign ln_mask   = SCAN_WIDTH'(1) << ln;
  assign conn_mask = SCAN_WIDTH'(1) << item.connect_line;

  always_comb begin
    pre_rx_ch    = rx_channel;
    pre_tx_ch    = tx_channel;
    pre_rx_armed = rx_scan_armed;
    pre_tx_armed = tx_scan_armed;
    pre_rx_pos   = rx_position;
    pre_ptr      = send_pointer_line;
    pre_ready    = ready_bits;
    pre_enable   = enable_bits;
    do_scan      = 1'b0;
    pre_rd       = '0;
    txv          = 1'b0;
    txl          = '0;
    txc          = '0;
    take         = 1'b0;
    case (cmd_t'(item.command))
      CMD_STATUS_RD: do_scan = rx_scan_armed || tx_scan_armed;
      CMD_CTRL_WR: begin
        pre_rx_ch = item.data_word[CTL_RX_CH_LSB +: CHAN_W];
        pre_tx_ch = item.data_word[CTL_TX_CH_LSB +: CHAN_W];
        if (item.data_word[CTL_RX_RESET]) pre_rx_pos = '0;
        if (item.data_word[CTL_RX_RESET] || item.data_word[CTL_RX_RELEASE]) begin
          pre_rx_armed = 1'b1;
        end
        if (item.data_word[CTL_TX_RELEASE]) begin
          pre_tx_armed = 1'b1;
          pre_enable   = enable_bits & ~(SCAN_WIDTH'(1) << tx_position);
        end
        do_scan = 1'b1;
      end
      CMD_DOUT_SCAN, CMD_DOUT_PTR: begin
        if (ln_ok && (ln < limit) && item.line_connected) begin
          txv        = 1'b1;
          txl        = ln[POS_W-1:0];
          txc        = item.data_word[CHAR_W-1:0];
          pre_enable = enable_bits | ln_mask;
        end
        if (cmd_t'(item.command) == CMD_DOUT_PTR) begin
          pre_tx_armed = 1'b1;
          do_scan      = 1'b1;
        end
      end
      CMD_DIN, CMD_DIN_REARM: begin
        if (ln < limit) begin
          if (item.rx_has_data) begin
            take       = 1'b1;
            pre_rd     = item.rx_break ? '0 : WORD_W'(item.rx_char);
            pre_enable = enable_bits & ~ln_mask;
          end
          pre_ready = ready_bits & ~ln_mask;
        end
        if (cmd_t'(item.command) == CMD_DIN_REARM) begin
          pre_rx_armed = 1'b1;
          do_scan      = 1'b1;
        end
      end
      CMD_SCAN_RD: begin
        pre_rd = WORD_W'(rx_scan_armed ? tx_position : rx_position) + WORD_W'(PTR_OFFSET);
      end
      CMD_SET_PTR: pre_ptr = item.data_word[PTR_W-1:0];
      CMD_POLL: begin
        if (item.connect_valid && ({1'b0, item.connect_line} < limit)) begin
          pre_enable = enable_bits | conn_mask;
        end
        pre_ready = ready_bits | (item.pending_mask[SCAN_WIDTH-1:0] & limit_mask);
        do_scan   = 1'b1;
      end
      default: do_scan = 1'b0;
    endcase
  end

  lms_find #(.SCAN_WIDTH(SCAN_WIDTH)) u_rx_find (
    .bits  (pre_ready),
    .pos   (pre_rx_pos),
    .hit   (rx_hit),
    .found (rx_found)
  );

  lms_find #(.SCAN_WIDTH(SCAN_WIDTH)) u_tx_find (
    .bits  (pre_enable),
    .pos   (tx_position),
    .hit   (tx_hit),
    .found (tx_found)
  );

  // receive scanner first; a hit there blocks the transmit scanner
  always_comb begin
    rx_armed_next    = pre_rx_armed;
    tx_armed_next    = pre_tx_armed;
    rx_position_next = pre_rx_pos;
    tx_position_next = tx_position;
    irq_state_next   = irq_state;
    irq_level_next   = irq_level;
    if (do_scan) begin
      irq_state_next = 1'b0;
      irq_level_next = '0;
      if (pre_rx_armed && rx_hit) begin
        rx_armed_next    = 1'b0;
        rx_position_next = rx_found;
        if (pre_rx_ch != '0) begin
          irq_state_next = 1'b1;
          irq_level_next = pre_rx_ch;
        end
      end else if (pre_tx_armed && tx_hit) begin
        tx_armed_next    = 1'b0;
        tx_position_next = tx_found;
        if (pre_tx_ch != '0) begin
          irq_state_next = 1'b1;
          irq_level_next = pre_tx_ch;
        end
      end
    end
    rd = pre_rd;
    if (cmd_t'(item.command) == CMD_STATUS_RD) begin
      rd = '0;
      rd[STAT_RX_CH_LSB +: CHAN_W] = pre_rx_ch;
      rd[STAT_RX_IDLE]             = !rx_armed_next;
      rd[STAT_TX_CH_LSB +: CHAN_W] = pre_tx_ch;
      rd[STAT_TX_IDLE]             = !tx_armed_next;
    end
  end

  always_comb begin
    result.read_data   = rd;
    result.tx_valid    = txv;
    result.tx_line     = txl;
    result.tx_char     = txc;
    result.rx_take     = take;
    result.irq_active  = irq_state_next;
    result.irq_channel = irq_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_channel        <= '0;
      tx_channel        <= '0;
      rx_scan_armed     <= 1'b0;
      tx_scan_armed     <= 1'b0;
      rx_position       <= '0;
      tx_position       <= '0;
      send_pointer_line <= '0;
      ready_bits        <= '0;
      enable_bits       <= '0;
      irq_state         <= 1'b0;
      irq_level         <= '0;
    end else if (step) begin
      rx_channel        <= pre_rx_ch;
      tx_channel        <= pre_tx_ch;
      rx_scan_armed     <= rx_armed_next;
      tx_scan_armed     <= tx_armed_next;
      rx_position       <= rx_position_next;
      tx_position       <= tx_position_next;
      send_pointer_line <= pre_ptr;
      ready_bits        <= pre_ready;
      enable_bits       <= pre_enable;
      irq_state         <= irq_state_next;
      irq_level         <= irq_level_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/terminal_mux_line_scanner_top.sv]
// Terminal mux line scanner, top level: request register, result register,
// line_count register. Depends on lms_pkg and lms_engine.
//
// Use: each request on the input channel (in_valid / in_stall) is one bus
// access or one poll event, selected by command. It is taken at a rising edge
// with in_valid high and in_stall low and lands in the request register.
// Once out_stall lets the result register advance, the engine evaluates it
// against the scanner state in one pass and loads the result register, which
// drives out_valid and the result fields. Exactly one result comes out per
// request, in order. Throughput: one request per cycle while the result is
// not held by out_stall.
// A result held by out_stall holds the result register; the request register
// still takes one more request, then in_stall rises until the result drains.
// line_count is written through cfg_valid / cfg_ready / cfg_data; cfg_ready is
// always high, and writes are expected only while no request is in flight.
// Reset (rst, synchronous) empties both registers, sets line_count to 16 and
// clears scanners, bitmaps, pointer and interrupt.
`default_nettype none

module terminal_mux_line_scanner_top #(
  parameter int SCAN_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [lms_pkg::CMD_W-1:0]       command,
  input  wire logic [lms_pkg::WORD_W-1:0]      data_word,
  input  wire logic                            connect_valid,
  input  wire logic [lms_pkg::POS_W-1:0]       connect_line,
  input  wire logic [lms_pkg::MASK_W-1:0]      pending_mask,
  input  wire logic                            line_connected,
  input  wire logic                            rx_has_data,
  input  wire logic [lms_pkg::CHAR_W-1:0]      rx_char,
  input  wire logic                            rx_break,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [lms_pkg::WORD_W-1:0]           read_data,
  output logic                                 tx_valid,
  output logic [lms_pkg::POS_W-1:0]            tx_line,
  output logic [lms_pkg::CHAR_W-1:0]           tx_char,
  output logic                                 rx_take,
  output logic                                 irq_active,
  output logic [lms_pkg::CHAN_W-1:0]           irq_channel,
  // configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lms_pkg::LINE_CNT_W-1:0]  cfg_data
);
  import lms_pkg::*;

  logic                  req_valid;
  item_t                 req_item;
  logic                  advance;
  logic                  fire;
  logic                  in_accept;
  result_t               step_result;
  result_t               res;
  logic [LINE_CNT_W-1:0] line_count;

  assign advance   = !out_valid || !out_stall;
  assign fire      = req_valid && advance;
  assign in_stall  = req_valid && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= LINE_CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_accept) begin
      req_valid <= 1'b1;
    end else if (fire) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_item.command        <= command;
      req_item.data_word      <= data_word;
      req_item.connect_valid  <= connect_valid;
      req_item.connect_line   <= connect_line;
      req_item.pending_mask   <= pending_mask;
      req_item.line_connected <= line_connected;
      req_item.rx_has_data    <= rx_has_data;
      req_item.rx_char        <= rx_char;
      req_item.rx_break       <= rx_break;
    end
  end

  lms_engine #(.SCAN_WIDTH(SCAN_WIDTH)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (fire),
    .item       (req_item),
    .line_count (line_count),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= step_result;
    end
  end

  assign read_data   = res.read_data;
  assign tx_valid    = res.tx_valid;
  assign tx_line     = res.tx_line;
  assign tx_char     = res.tx_char;
  assign rx_take     = res.rx_take;
  assign irq_active  = res.irq_active;
  assign irq_channel = res.irq_channel;

endmodule

`default_nettype wire

[hw/rtl/lms_checker.sv]
// Port-level checks for the terminal mux line scanner, bound to the top level.
// Sees only the top-level ports; no package use.
`default_nettype none

module lms_checker #(
  parameter int SCAN_WIDTH = 32
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [11:0] read_data,
  input wire logic        tx_valid,
  input wire logic [4:0]  tx_line,
  input wire logic [7:0]  tx_char,
  input wire logic        irq_active,
  input wire logic [2:0]  irq_channel
);

  // a send only targets a line inside the scanned range, and idle sends are zero
  a_tx_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tx_valid ? ({1'b0, tx_line} < 6'(SCAN_WIDTH))
                            : (tx_line == '0 && tx_char == '0)))
    else $error("tx fields inconsistent with tx_valid");

  // raised request always carries a nonzero channel, dropped one carries zero
  a_irq_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq_active == (irq_channel != 3'd0)))
    else $error("irq channel inconsistent with irq_active");

  // no result shows up in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(tx_valid)
      && $stable(irq_active) && $stable(irq_channel))
    else $error("stalled result changed");

endmodule

bind terminal_mux_line_scanner_top lms_checker #(.SCAN_WIDTH(SCAN_WIDTH)) u_lms_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_data   (read_data),
  .tx_valid    (tx_valid),
  .tx_line     (tx_line),
  .tx_char     (tx_char),
  .irq_active  (irq_active),
  .irq_channel (irq_channel)
);

`default_nettype wire
